// ===== rtl/core/bsa_pkg.sv =====
// Shared types and constants for the banker's-algorithm allocation guard.
package bsa_pkg;

    localparam int AMT_W       = 12;  // width of a request amount / avail output field
    localparam int CFG_W       = 48;  // width of one configuration register
    localparam int CFG_IDX_W   = 3;
    localparam int DEMAND_REGS = 4;   // customers that own a demand register
    localparam int MAX_RES     = 4;   // resource fields carried on the stream
    localparam int SEL_W       = 3;   // wide enough for any customer index

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMAND0 = 3'd1;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NEED    = 3'd1,
        ST_AVAIL   = 3'd2,
        ST_UNSAFE  = 3'd3,
        ST_RELEASE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_APPLY,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic en;   // update the row of the current customer
        logic sub;  // 1: release (subtract), 0: grant (add)
    } t_store_cmd;

endpackage

// ===== rtl/core/bankers_safe_allocation.sv =====
// Banker's-algorithm allocation guard: top level, sequencer and config registers.
//
// Usage:
//  - Configure total units (index 0) and per-customer maximum demand
//    (indexes 1..4) through the write port while the block is idle; each
//    register packs UNIT_BITS-wide fields, resource r at bit r*UNIT_BITS.
//  - Each slave request carries an opcode in tuser (request or release), a
//    customer and four amounts; each result carries granted, a status code
//    and the available units after the access.
//  - An accepted request is checked first; a refused one goes straight to the
//    result stage, a release goes on to update the table, and any other
//    request reaches the safety scan. The scan tests one customer per cycle in
//    the shared check unit, for at most CUSTOMERS passes, stopping after a
//    pass at whose end all have finished or in which none did.
//  - One request is in work at a time; s_axis_tready is high only in idle, so
//    no new request is taken before the previous one leaves the sequencer. A
//    finished result sits in the output register; the next request is accepted
//    meanwhile and its own result waits until the receiver takes the previous one.
//  - Synchronous active-low reset clears the allocation table, the
//    configuration registers and the output valid.
module bankers_safe_allocation
    import bsa_pkg::*;
#(
    parameter int CUSTOMERS = 4,
    parameter int RESOURCES = 4,
    parameter int UNIT_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // customer[1:0], amount_r0..r3 (12 b each)
    input  logic                 s_axis_tuser,  // opcode
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata   // granted, status[2:0], avail_r0..r3 (12 b each)
);

    localparam int IW = $clog2(CUSTOMERS);
    localparam int SW = UNIT_BITS + 3;                        // column sum width
    localparam int MW = (UNIT_BITS > AMT_W) ? UNIT_BITS : AMT_W;
    localparam int CW = MW + 3;                               // work vector width

    function automatic logic [UNIT_BITS-1:0] field_of(input logic [CFG_W-1:0] reg_v,
                                                      input int idx);
        logic [2*CFG_W-1:0] wide;
        wide = {CFG_W'(0), reg_v} >> (idx * UNIT_BITS);
        return wide[UNIT_BITS-1:0];
    endfunction

    // configuration
    logic [CFG_W-1:0] r_total;
    logic [CFG_W-1:0] r_demand [DEMAND_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int c = 0; c < DEMAND_REGS; c++) begin
                r_demand[c] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TOTAL) begin
                r_total <= i_cfg_data;
            end else if (i_cfg_index >= CFG_DEMAND0 &&
                         i_cfg_index < CFG_DEMAND0 + CFG_IDX_W'(DEMAND_REGS)) begin
                r_demand[2'(i_cfg_index - CFG_DEMAND0)] <= i_cfg_data;
            end
        end
    end

    // sequencer state
    t_state               r_state, n_state;
    t_op                  r_op;
    logic [1:0]           r_cust;
    logic [AMT_W-1:0]     r_amt  [MAX_RES];
    logic [CW-1:0]        r_work [RESOURCES], n_work [RESOURCES];
    logic [CUSTOMERS-1:0] r_done, n_done;
    logic [IW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_pass, n_pass;
    logic                 r_prog, n_prog;
    t_status              r_status, n_status;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_granted, n_granted;
    t_status              r_out_status, n_out_status;
    logic [AMT_W-1:0]     r_out_avail [MAX_RES], n_out_avail [MAX_RES];

    logic                 accept;
    logic                 cust_valid;
    logic [SEL_W-1:0]     dem_sel;
    logic [IW-1:0]        rd_row;
    t_store_cmd           store_cmd;

    logic [UNIT_BITS-1:0] row      [RESOURCES];
    logic [UNIT_BITS-1:0] alloc_in [RESOURCES];
    logic [SW-1:0]        colsum   [RESOURCES];
    logic [UNIT_BITS-1:0] avail    [RESOURCES];
    logic [UNIT_BITS-1:0] demand   [RESOURCES];
    logic [UNIT_BITS-1:0] total_f;
    logic [MW-1:0]        avail_ext;

    t_status              u_status;
    logic                 u_fits;
    logic [CW-1:0]        u_work [RESOURCES];

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign cust_valid = SEL_W'(r_cust) < SEL_W'(CUSTOMERS);
    assign rd_row     = (r_state == S_SCAN) ? r_idx : IW'(r_cust);
    assign dem_sel    = (r_state == S_SCAN) ? SEL_W'(r_idx) : SEL_W'(r_cust);

    always_comb begin
        total_f = '0;
        for (int r = 0; r < RESOURCES; r++) begin
            total_f     = field_of(r_total, r);
            avail[r]    = (SW'(total_f) > colsum[r]) ? UNIT_BITS'(SW'(total_f) - colsum[r])
                                                     : '0;
            demand[r]   = (dem_sel < SEL_W'(DEMAND_REGS))
                        ? field_of(r_demand[dem_sel[1:0]], r) : '0;
            // the requester's row reads as zero when it has no table entry
            alloc_in[r] = (r_state == S_SCAN || cust_valid) ? row[r] : '0;
        end
    end

    bsa_alloc_store #(
        .CUSTOMERS (CUSTOMERS),
        .RESOURCES (RESOURCES),
        .UNIT_BITS (UNIT_BITS),
        .IW        (IW),
        .SW        (SW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (store_cmd),
        .i_wr_row (IW'(r_cust)),
        .i_amt    (r_amt),
        .i_rd_row (rd_row),
        .o_row    (row),
        .o_colsum (colsum)
    );

    bsa_check_unit #(
        .RESOURCES (RESOURCES),
        .UNIT_BITS (UNIT_BITS),
        .CW        (CW)
    ) u_check (
        .i_op      (r_op),
        .i_is_cust ((r_state == S_SCAN) && cust_valid &&
                    (SEL_W'(r_idx) == SEL_W'(r_cust))),
        .i_amt     (r_amt),
        .i_alloc   (alloc_in),
        .i_demand  (demand),
        .i_avail   (avail),
        .i_work    (r_work),
        .o_status  (u_status),
        .o_fits    (u_fits),
        .o_work    (u_work)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(s_axis_tuser);
            r_cust <= s_axis_tdata[1:0];
            for (int r = 0; r < MAX_RES; r++) begin
                r_amt[r] <= s_axis_tdata[2 + r*AMT_W +: AMT_W];
            end
        end
        r_work       <= n_work;
        r_done       <= n_done;
        r_idx        <= n_idx;
        r_pass       <= n_pass;
        r_prog       <= n_prog;
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_out_status <= n_out_status;
        r_out_avail  <= n_out_avail;
    end

    always_comb begin
        logic scan_fits;
        logic [CUSTOMERS-1:0] done_now;

        n_state       = r_state;
        n_work        = r_work;
        n_done        = r_done;
        n_idx         = r_idx;
        n_pass        = r_pass;
        n_prog        = r_prog;
        n_status      = r_status;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_granted     = r_granted;
        n_out_status  = r_out_status;
        n_out_avail   = r_out_avail;
        store_cmd     = '0;
        s_axis_tready = (r_state == S_IDLE);
        scan_fits     = !r_done[r_idx] && u_fits;
        done_now      = r_done;
        avail_ext     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_status = u_status;
                if (u_status != ST_OK) begin
                    n_state = S_RESULT;
                end else if (r_op == OP_RELEASE) begin
                    n_state = S_APPLY;
                end else begin
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_work[r] = CW'(avail[r]) - CW'(r_amt[r]);
                    end
                    n_done  = '0;
                    n_idx   = '0;
                    n_pass  = '0;
                    n_prog  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_fits) begin
                    n_work           = u_work;
                    done_now[r_idx]  = 1'b1;
                    n_done           = done_now;
                    n_prog           = 1'b1;
                end
                if (r_idx == IW'(CUSTOMERS - 1)) begin
                    if (&done_now) begin
                        n_status = ST_OK;
                        n_state  = S_APPLY;
                    end else if (!(r_prog || scan_fits) ||
                                 r_pass == IW'(CUSTOMERS - 1)) begin
                        n_status = ST_UNSAFE;
                        n_state  = S_RESULT;
                    end else begin
                        n_idx  = '0;
                        n_pass = r_pass + 1'b1;
                        n_prog = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_APPLY: begin
                store_cmd.en  = cust_valid;
                store_cmd.sub = (r_op == OP_RELEASE);
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_granted    = (r_status == ST_OK);
                    n_out_status = r_status;
                    for (int r = 0; r < MAX_RES; r++) begin
                        n_out_avail[r] = '0;
                    end
                    for (int r = 0; r < RESOURCES; r++) begin
                        avail_ext      = MW'(avail[r]);
                        n_out_avail[r] = avail_ext[AMT_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_avail[3], r_out_avail[2], r_out_avail[1],
                            r_out_avail[0], r_out_status, r_granted};

`ifndef ASSERT_OFF
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CHECK))
        else $error("accepted request did not enter the check step");

    a_scan_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (int'(r_idx) < CUSTOMERS))
        else $error("scan index beyond last customer");

    a_apply_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> (r_status == ST_OK))
        else $error("table update on a refused request");

    a_later_pass_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pass != '0) |-> (r_done != '0))
        else $error("extra scan pass without any finished customer");

    a_grant_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_granted == (r_out_status == ST_OK)))
        else $error("granted flag disagrees with status");
`endif

endmodule

// ===== rtl/core/bsa_alloc_store.sv =====
// Allocation table and running column sums.
module bsa_alloc_store
    import bsa_pkg::*;
#(
    parameter int CUSTOMERS = 4,
    parameter int RESOURCES = 4,
    parameter int UNIT_BITS = 12,
    parameter int IW        = 2,
    parameter int SW        = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_store_cmd           i_cmd,
    input  logic [IW-1:0]        i_wr_row,
    input  logic [AMT_W-1:0]     i_amt    [MAX_RES],
    input  logic [IW-1:0]        i_rd_row,
    output logic [UNIT_BITS-1:0] o_row    [RESOURCES],
    output logic [SW-1:0]        o_colsum [RESOURCES]
);

    logic [UNIT_BITS-1:0] r_table  [CUSTOMERS][RESOURCES];
    logic [SW-1:0]        r_colsum [RESOURCES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CUSTOMERS; c++) begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_table[c][r] <= '0;
                end
            end
            for (int r = 0; r < RESOURCES; r++) begin
                r_colsum[r] <= '0;
            end
        end else if (i_cmd.en) begin
            for (int r = 0; r < RESOURCES; r++) begin
                if (i_cmd.sub) begin
                    r_table[i_wr_row][r] <= r_table[i_wr_row][r] - UNIT_BITS'(i_amt[r]);
                    r_colsum[r]          <= r_colsum[r] - SW'(i_amt[r]);
                end else begin
                    r_table[i_wr_row][r] <= r_table[i_wr_row][r] + UNIT_BITS'(i_amt[r]);
                    r_colsum[r]          <= r_colsum[r] + SW'(i_amt[r]);
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < RESOURCES; r++) begin
            o_row[r]    = (int'(i_rd_row) < CUSTOMERS) ? r_table[i_rd_row][r] : '0;
            o_colsum[r] = r_colsum[r];
        end
    end

endmodule

// ===== rtl/core/bsa_check_unit.sv =====
// Shared check unit: need/available/release checks and one safety-scan step.
module bsa_check_unit
    import bsa_pkg::*;
#(
    parameter int RESOURCES = 4,
    parameter int UNIT_BITS = 12,
    parameter int CW        = 15
) (
    input  t_op                  i_op,
    input  logic                 i_is_cust,  // scanned row is the requester
    input  logic [AMT_W-1:0]     i_amt    [MAX_RES],
    input  logic [UNIT_BITS-1:0] i_alloc  [RESOURCES],
    input  logic [UNIT_BITS-1:0] i_demand [RESOURCES],
    input  logic [UNIT_BITS-1:0] i_avail  [RESOURCES],
    input  logic [CW-1:0]        i_work   [RESOURCES],
    output t_status              o_status,
    output logic                 o_fits,
    output logic [CW-1:0]        o_work   [RESOURCES]
);

    logic [UNIT_BITS-1:0] need  [RESOURCES];
    logic [CW-1:0]        amt_e [RESOURCES];
    logic [CW-1:0]        nd_t  [RESOURCES];
    logic [CW-1:0]        al_t  [RESOURCES];

    always_comb begin
        o_status = ST_OK;
        o_fits   = 1'b1;
        for (int r = 0; r < RESOURCES; r++) begin
            need[r]  = (i_demand[r] > i_alloc[r]) ? i_demand[r] - i_alloc[r] : '0;
            amt_e[r] = CW'(i_amt[r]);
            if (i_is_cust) begin
                nd_t[r] = CW'(need[r]) - amt_e[r];
                al_t[r] = CW'(i_alloc[r]) + amt_e[r];
            end else begin
                nd_t[r] = CW'(need[r]);
                al_t[r] = CW'(i_alloc[r]);
            end
            if (nd_t[r] > i_work[r]) begin
                o_fits = 1'b0;
            end
            o_work[r] = i_work[r] + al_t[r];

            // first failing resource decides; need before available
            if (i_op == OP_REQUEST) begin
                if (o_status == ST_OK) begin
                    if (amt_e[r] > CW'(need[r])) begin
                        o_status = ST_NEED;
                    end else if (amt_e[r] > CW'(i_avail[r])) begin
                        o_status = ST_AVAIL;
                    end
                end
            end else if (amt_e[r] > CW'(i_alloc[r])) begin
                o_status = ST_RELEASE;
            end
        end
    end

endmodule

// ===== test/bsa_checker.sv =====
// Scoreboard for the allocation guard: tracks config, predicts each outcome, checks results.
`timescale 1ns / 100ps

module bsa_checker
    import bsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [55:0]          i_req_data,   // customer[1:0], amount_r0..r3 (12 b each)
    input  logic                 i_req_user,   // opcode
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  logic [55:0]          i_rsp_data,   // granted, status[2:0], avail_r0..r3 (12 b each)
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int NCUST = 4;
    localparam int NRES  = 4;

    typedef logic [NRES-1:0][AMT_W-1:0] t_units;

    typedef struct packed {
        logic    granted;
        t_status status;
        t_units  avail;
    } t_outcome;

    logic [CFG_W-1:0] total_word;
    logic [CFG_W-1:0] demand_word [NCUST];
    logic [AMT_W-1:0] held [NCUST][NRES];
    t_outcome         outcomes_due [$];

    int       fails = 0;
    t_outcome want;
    t_units   req_amt;
    t_units   got_avail;
    logic     got_granted;
    logic [2:0] got_status;

    function automatic logic [AMT_W-1:0] need_now(int c, int r);
        logic [AMT_W-1:0] m;
        m = demand_word[c][r*AMT_W +: AMT_W];
        return (m > held[c][r]) ? m - held[c][r] : '0;
    endfunction

    // column sum can pass the total after a reconfig; clamp at zero
    function automatic logic [AMT_W-1:0] free_units(int r);
        logic [15:0]      sum;
        logic [AMT_W-1:0] t;
        sum = '0;
        t   = total_word[r*AMT_W +: AMT_W];
        for (int c = 0; c < NCUST; c++) sum += held[c][r];
        return ({4'd0, t} > sum) ? AMT_W'({4'd0, t} - sum) : '0;
    endfunction

    function automatic bit safe_after(int cust, t_units amt);
        logic [15:0]      work [NRES];
        logic [15:0]      alloc_c [NCUST][NRES];
        logic [AMT_W-1:0] need_c [NCUST][NRES];
        bit               done [NCUST];
        int               left;
        bit               progress;
        bit               fits;
        left = NCUST;
        for (int r = 0; r < NRES; r++) work[r] = {4'd0, free_units(r)} - amt[r];
        for (int c = 0; c < NCUST; c++) begin
            done[c] = 1'b0;
            for (int r = 0; r < NRES; r++) begin
                alloc_c[c][r] = held[c][r] + ((c == cust) ? amt[r] : '0);
                need_c[c][r]  = need_now(c, r) - ((c == cust) ? amt[r] : '0);
            end
        end
        for (int pass = 0; pass < NCUST && left > 0; pass++) begin
            progress = 1'b0;
            for (int c = 0; c < NCUST; c++) begin
                if (!done[c]) begin
                    fits = 1'b1;
                    for (int r = 0; r < NRES; r++)
                        if ({4'd0, need_c[c][r]} > work[r]) fits = 1'b0;
                    if (fits) begin
                        for (int r = 0; r < NRES; r++) work[r] += alloc_c[c][r];
                        done[c]  = 1'b1;
                        left--;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) break;
        end
        return left == 0;
    endfunction

    // decides grant/refusal and applies a granted access to the table
    function automatic t_outcome banker_decide(t_op op, logic [1:0] cust, t_units amt);
        t_outcome res;
        t_status  st;
        st = ST_OK;
        if (op == OP_REQUEST) begin
            for (int r = 0; r < NRES; r++) begin
                if (st == ST_OK) begin
                    if (amt[r] > need_now(cust, r))
                        st = ST_NEED;
                    else if (amt[r] > free_units(r))
                        st = ST_AVAIL;
                end
            end
            if (st == ST_OK && !safe_after(cust, amt)) st = ST_UNSAFE;
            if (st == ST_OK)
                for (int r = 0; r < NRES; r++) held[cust][r] += amt[r];
        end else begin
            for (int r = 0; r < NRES; r++)
                if (amt[r] > held[cust][r]) st = ST_RELEASE;
            if (st == ST_OK)
                for (int r = 0; r < NRES; r++) held[cust][r] -= amt[r];
        end
        res.granted = (st == ST_OK);
        res.status  = st;
        for (int r = 0; r < NRES; r++) res.avail[r] = free_units(r);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            total_word  = '0;
            demand_word = '{default: '0};
            held        = '{default: '0};
            outcomes_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TOTAL)
                    total_word = i_cfg_data;
                else if (i_cfg_index >= CFG_DEMAND0 && i_cfg_index < CFG_DEMAND0 + DEMAND_REGS)
                    demand_word[i_cfg_index - CFG_DEMAND0] = i_cfg_data;
            end
            // result first: it always belongs to an earlier request
            if (i_rsp_valid && i_rsp_ready) begin
                got_granted = i_rsp_data[0];
                got_status  = i_rsp_data[3:1];
                got_avail   = i_rsp_data[51:4];
                if (outcomes_due.size() == 0) begin
                    $error("result with no request outstanding: data %h", i_rsp_data);
                    fails++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (got_granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, got_granted);
                        fails++;
                    end
                    if (got_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got_status);
                        fails++;
                    end
                    for (int r = 0; r < NRES; r++) begin
                        if (got_avail[r] !== want.avail[r]) begin
                            $error("avail_r%0d: expected %0d, got %0d",
                                   r, want.avail[r], got_avail[r]);
                            fails++;
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                for (int r = 0; r < NRES; r++) req_amt[r] = i_req_data[2 + r*AMT_W +: AMT_W];
                outcomes_due.push_back(banker_decide(t_op'(i_req_user), i_req_data[1:0],
                                                     req_amt));
            end
        end
        o_pending = outcomes_due.size();
    end

    assign o_fail_count = fails;

endmodule

// ===== test/testbench.sv =====
// Top of the allocation guard testbench: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module testbench;
    import bsa_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int PHASES          = 6;
    localparam int TAIL_CYCLES     = 30;

    typedef logic [MAX_RES-1:0][AMT_W-1:0] t_units;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [55:0]          s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [55:0]          m_tdata;

    int fail_count;
    int pending;
    int tx_gap_pct   = 29;
    int rx_stall_pct = 81;
    bit hold_req     = 1'b0;
    bit hold_armed   = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    logic [CFG_W-1:0] total_cfg = '0;
    logic [CFG_W-1:0] demand_cfg [DEMAND_REGS] = '{default: '0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bankers_safe_allocation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    bsa_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_req_user   (s_tuser),
        .i_rsp_valid  (m_tvalid),
        .i_rsp_ready  (m_tready),
        .i_rsp_data   (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random stalls, plus one long hold-off on demand
    always @(posedge i_clk) begin
        if (hold_req && !hold_armed) begin
            hold_left  = HOLD_CYCLES;
            hold_armed = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** bankers_safe_allocation: FAILED **");
            $finish;
        end
    end

    function automatic t_units units4(int a0, int a1, int a2, int a3);
        return {AMT_W'(a3), AMT_W'(a2), AMT_W'(a1), AMT_W'(a0)};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TOTAL)
            total_cfg = value;
        else
            demand_cfg[idx - CFG_DEMAND0] = value;
    endtask

    task automatic write_demands(t_units d0, t_units d1, t_units d2, t_units d3);
        write_reg(CFG_DEMAND0,                d0);
        write_reg(CFG_IDX_W'(CFG_DEMAND0 + 1), d1);
        write_reg(CFG_IDX_W'(CFG_DEMAND0 + 2), d2);
        write_reg(CFG_IDX_W'(CFG_DEMAND0 + 3), d3);
    endtask

    // valid stays high into the next request unless a gap is drawn
    task automatic offer(t_op op, logic [1:0] cust, t_units amt);
        while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, amt, cust};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic program_random(int lo, int hi, bit demand_free);
        t_units tot;
        t_units dem;
        for (int r = 0; r < MAX_RES; r++) tot[r] = AMT_W'($urandom_range(hi, lo));
        write_reg(CFG_TOTAL, tot);
        for (int c = 0; c < DEMAND_REGS; c++) begin
            for (int r = 0; r < MAX_RES; r++)
                dem[r] = demand_free ? AMT_W'($urandom_range(4095, 0))
                                     : AMT_W'($urandom_range(tot[r], 0));
            write_reg(CFG_IDX_W'(CFG_DEMAND0 + c), dem);
        end
    endtask

    initial begin
        int     pick;
        int     dem;
        t_op    op;
        logic [1:0] cust;
        t_units amt;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: textbook-sized table
        write_reg(CFG_TOTAL, units4(10, 5, 7, 4));
        write_demands(units4(7, 5, 3, 2), units4(3, 2, 2, 1),
                      units4(9, 0, 2, 3), units4(4, 3, 3, 2));
        offer(OP_REQUEST, 2'd0, units4(0, 0, 0, 0));
        offer(OP_REQUEST, 2'd0, units4(3, 2, 1, 1));
        offer(OP_REQUEST, 2'd1, units4(2, 1, 1, 0));
        offer(OP_REQUEST, 2'd0, units4(8, 0, 0, 0));            // over need
        offer(OP_REQUEST, 2'd2, units4(0, 1, 0, 0));            // zero demand column
        offer(OP_REQUEST, 2'd3, units4(4, 0, 0, 0));
        offer(OP_REQUEST, 2'd1, units4(0, 0, 0, 1));
        offer(OP_RELEASE, 2'd1, units4(3, 0, 0, 0));            // over allocation
        offer(OP_RELEASE, 2'd0, units4(4095, 4095, 4095, 4095));
        offer(OP_REQUEST, 2'd3, units4(4095, 4095, 4095, 4095));
        drain();
        // total below column sums: avail clamps, state goes unsafe
        write_reg(CFG_TOTAL, units4(1, 1, 1, 1));
        offer(OP_REQUEST, 2'd2, units4(0, 0, 0, 0));
        offer(OP_REQUEST, 2'd0, units4(0, 0, 0, 0));
        offer(OP_RELEASE, 2'd0, units4(3, 2, 1, 1));
        drain();
        // demand dropped under allocation: need clamps at zero
        write_reg(CFG_TOTAL, '0);
        write_reg(CFG_IDX_W'(CFG_DEMAND0 + 1), '0);
        offer(OP_REQUEST, 2'd1, units4(0, 0, 0, 0));
        offer(OP_RELEASE, 2'd1, units4(2, 1, 1, 0));
        offer(OP_REQUEST, 2'd0, units4(1, 0, 0, 0));
        drain();
        write_reg(CFG_TOTAL, '1);
        write_demands('1, '1, '1, '1);
        offer(OP_REQUEST, 2'd0, units4(4095, 4095, 4095, 4095));
        offer(OP_REQUEST, 2'd2, units4(4095, 0, 0, 0));
        offer(OP_RELEASE, 2'd0, units4(4095, 4095, 4095, 4095));
        offer(OP_RELEASE, 2'd3, units4(4095, 4095, 4095, 4095));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p / 2)
                0: begin tx_gap_pct = 29; rx_stall_pct = 81; end
                1: begin tx_gap_pct = 81; rx_stall_pct = 29; end
                default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
            endcase
            // allocations carry over, so new limits may land under them
            case (p)
                2: begin
                    write_reg(CFG_TOTAL, '1);
                    write_demands('1, '1, '1, '1);
                end
                3:       program_random(0, 15, 1'b1);
                5:       program_random(1, 4095, 1'b0);
                default: program_random(16, 63, 1'b0);
            endcase
            if (p == 4) hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                cust = 2'($urandom_range(3));
                for (int r = 0; r < MAX_RES; r++) begin
                    dem = int'(demand_cfg[cust][r*AMT_W +: AMT_W]);
                    if (pick < 50)
                        amt[r] = AMT_W'($urandom_range(dem / 3 + 1, 0));
                    else if (pick < 88)
                        amt[r] = AMT_W'($urandom_range(dem / 4 + 1, 0));
                    else if (pick < 93)
                        amt[r] = '0;
                    else
                        amt[r] = AMT_W'($urandom_range(4095, 0));
                end
                if (pick < 50)
                    op = OP_REQUEST;
                else if (pick < 88)
                    op = OP_RELEASE;
                else
                    op = t_op'($urandom_range(1));
                offer(op, cust, amt);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** bankers_safe_allocation: PASSED **");
        else
            $display("** bankers_safe_allocation: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bsa_pkg.sv
rtl/core/bsa_alloc_store.sv
rtl/core/bsa_check_unit.sv
rtl/core/bankers_safe_allocation.sv
test/bsa_checker.sv
test/testbench.sv
